// ===== rtl/pom_pkg.sv =====
// shared types, constants and tables of the polyphonic oscillator mixer
package pom_pkg;

    localparam int VOICES          = 16;
    localparam int KEYS            = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int OCT_MAX = (VOICES - 1) / 12;
    localparam int OCT_W   = (OCT_MAX > 0) ? $clog2(OCT_MAX + 1) : 1;
    localparam int SUM_W   = $clog2(VOICES) + 11;

    localparam int PHASE_W = 32;
    localparam int BASE_W  = 31;
    localparam int VOL_W   = 8;
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = 17;
    localparam int X_W     = 16;
    localparam int TERM_W  = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC = 2'd2;

    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_TRIANGLE,
        WAVE_SQUARE,
        WAVE_SAWTOOTH
    } wave_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_ADV,
        ST_SQ,
        ST_INNER,
        ST_MID,
        ST_MAG,
        ST_SCALE,
        ST_ACC,
        ST_DONE
    } state_t;

    localparam logic [VOL_W-1:0]  VOLUME_RESET   = 8'd51;
    localparam logic [BASE_W-1:0] BASE_INC_RESET = 31'd19685267;

    localparam logic [MAG_W-1:0]   FULL_SCALE = 17'd32768;
    localparam logic [MUL_B_W-1:0] POLY_A     = 17'd51472;
    localparam logic [MUL_B_W-1:0] POLY_B     = 17'd21024;
    localparam logic [MUL_B_W-1:0] POLY_C     = 17'd2320;

    localparam logic [PHASE_W-1:0] SINE_KEEP =
        {{SINE_TABLE_BITS{1'b1}}, {(PHASE_W - SINE_TABLE_BITS){1'b0}}};

    // 2^(n/12) in q16, rounded
    function automatic logic [MUL_B_W-1:0] semitone_q16(input logic [3:0] semi);
        logic [MUL_B_W-1:0] r;
        case (semi)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/pom_if.sv =====
// handshake channels of the oscillator mixer: key ticks, samples and register writes
interface pom_tick_if;
    import pom_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEYS-1:0]  key_mask;

    modport source (output valid, output key_mask, input ready);
    modport sink   (input valid, input key_mask, output ready);
endinterface

interface pom_sample_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample;
    logic              clipped;

    modport source (output valid, output sample, output clipped, input ready);
    modport sink   (input valid, input sample, input clipped, output ready);
endinterface

interface pom_cfg_if;
    import pom_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pom_ram.sv =====
// generic single write port ram with registered read
module pom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/polyphonic_oscillator_mixer_unit.sv =====
// per item: idle and done states plus, for each voice, read, step and advance states;
// a held voice adds scale and accumulate, and with sine also square, inner, mid and mag
// a new item is taken only once the last one is done; the single shared 31x17 multiplier and the
// phase ram port walk the voices one at a time
// reset: control and config registers to their defaults, phases read as zero through
// per-voice valid bits, no clearing pass; ready as soon as reset is released
module polyphonic_oscillator_mixer_unit
    import pom_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pom_cfg_if.sink       cfg,
    pom_tick_if.sink      tick,
    pom_sample_if.source  mix
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(128);

    state_t state_reg;
    state_t state_next;

    wave_t                waveform_reg;
    logic [VOL_W-1:0]     volume_reg;
    logic [BASE_W-1:0]    base_reg;

    logic [VIDX_W-1:0]    j_reg;
    logic [3:0]           semi_reg;
    logic [OCT_W-1:0]     oct_reg;
    logic [KEYS-1:0]      mask_reg;
    logic [VOICES-1:0]    valid_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [X_W-1:0]       x_reg;
    logic [X_W-1:0]       x2_reg;
    logic [MAG_W-1:0]     aw_reg;
    logic                 neg_reg;

    logic signed [7:0]    sample_reg;
    logic                 clipped_reg;
    logic                 out_valid_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 ram_we;
    logic                 ram_re;
    logic [PHASE_W-1:0]   ram_rdata;

    logic [63:0]          step_wide;
    logic [PHASE_W-1:0]   step;
    logic [PHASE_W-1:0]   wphase;
    logic [X_W-1:0]       x_cur;
    logic [MAG_W-1:0]     aw_cur;
    logic                 neg_cur;
    logic [6:0]           j_ext;
    logic                 held;
    logic                 last;
    logic                 advance;
    logic                 accept;
    logic                 load_out;
    logic [14:0]          vol127;
    logic [TERM_W-1:0]    term;

    assign accept   = tick.valid && tick.ready;
    assign cfg.ready = 1'b1;

    assign step_wide = 64'(prod_reg) << oct_reg;
    assign step      = step_wide[47:16];
    assign j_ext     = 7'(j_reg);
    assign held      = (j_ext < 7'(KEYS)) && mask_reg[j_ext[3:0]];
    assign last      = (j_reg == VIDX_W'(VOICES - 1));
    assign vol127    = {volume_reg, 7'b0} - 15'(volume_reg);
    assign term      = prod_reg[31:23];
    assign advance   = ((state_reg == ST_ADV) && !held) || (state_reg == ST_ACC);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || mix.ready);

    // waveform value at the phase before the advance, as sign and magnitude
    always_comb
    begin
        wphase = (waveform_reg == WAVE_SINE) ? (phase_reg & SINE_KEEP) : phase_reg;
        x_cur  = wphase[30] ? X_W'(FULL_SCALE - {2'b0, wphase[29:15]})
                            : {1'b0, wphase[29:15]};
        aw_cur  = '0;
        neg_cur = wphase[31];
        case (waveform_reg)
            WAVE_SINE:
            begin
                aw_cur  = '0;
                neg_cur = wphase[31];
            end
            WAVE_TRIANGLE:
            begin
                aw_cur  = {1'b0, x_cur};
                neg_cur = wphase[31];
            end
            WAVE_SQUARE:
            begin
                aw_cur  = FULL_SCALE;
                neg_cur = phase_reg[31];
            end
            default:
            begin
                if (phase_reg[31])
                begin
                    aw_cur  = {2'b0, phase_reg[30:16]};
                    neg_cur = 1'b0;
                end
                else
                begin
                    aw_cur  = FULL_SCALE - {1'b0, phase_reg[31:16]};
                    neg_cur = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_STEP;
            ST_STEP:  state_next = ST_ADV;
            ST_ADV:
            begin
                if (!held)
                begin
                    state_next = last ? ST_DONE : ST_READ;
                end
                else if (waveform_reg == WAVE_SINE)
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SQ:    state_next = ST_INNER;
            ST_INNER: state_next = ST_MID;
            ST_MID:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ACC;
            ST_ACC:   state_next = last ? ST_DONE : ST_READ;
            ST_DONE:
            begin
                if (!out_valid_reg || mix.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick.ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE:  tick.ready = 1'b1;
            ST_READ:  ram_re = 1'b1;
            ST_STEP:
            begin
                mul_a = base_reg;
                mul_b = semitone_q16(semi_reg);
            end
            ST_ADV:
            begin
                ram_we = 1'b1;
                mul_a  = MUL_A_W'(x_cur);
                mul_b  = MUL_B_W'(x_cur);
            end
            ST_SQ:
            begin
                mul_a = MUL_A_W'(prod_reg[30:15]);
                mul_b = POLY_C;
            end
            ST_INNER:
            begin
                mul_a = MUL_A_W'(x2_reg);
                mul_b = POLY_B - prod_reg[31:15];
            end
            ST_MID:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = POLY_A - prod_reg[31:15];
            end
            ST_SCALE:
            begin
                mul_a = MUL_A_W'(aw_reg);
                mul_b = MUL_B_W'(vol127);
            end
            default:
            begin
                tick.ready = 1'b0;
            end
        endcase
    end

    pom_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (VOICES)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_reg),
        .wdata (phase_reg + step),
        .re    (ram_re),
        .raddr (j_reg),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            waveform_reg  <= WAVE_SINE;
            volume_reg    <= VOLUME_RESET;
            base_reg      <= BASE_INC_RESET;
            valid_reg     <= '0;
            j_reg         <= '0;
            semi_reg      <= '0;
            oct_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_WAVEFORM: waveform_reg <= wave_t'(cfg.data[1:0]);
                    CFG_VOLUME:   volume_reg   <= cfg.data[VOL_W-1:0];
                    CFG_BASE_INC: base_reg     <= cfg.data[BASE_W-1:0];
                    default:      ;
                endcase
            end
            if (ram_we)
            begin
                valid_reg[j_reg] <= 1'b1;
            end
            if (accept)
            begin
                mask_reg <= tick.key_mask;
                j_reg    <= '0;
                semi_reg <= '0;
                oct_reg  <= '0;
            end
            else if (advance && !last)
            begin
                j_reg <= j_reg + 1'b1;
                if (semi_reg == 4'd11)
                begin
                    semi_reg <= '0;
                    oct_reg  <= oct_reg + 1'b1;
                end
                else
                begin
                    semi_reg <= semi_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= 48'(mul_a) * 48'(mul_b);
        if (accept)
        begin
            sum_reg <= '0;
        end
        case (state_reg)
            ST_STEP:
            begin
                phase_reg <= valid_reg[j_reg] ? ram_rdata : '0;
            end
            ST_ADV:
            begin
                x_reg   <= x_cur;
                aw_reg  <= aw_cur;
                neg_reg <= neg_cur;
            end
            ST_SQ:
            begin
                x2_reg <= prod_reg[30:15];
            end
            ST_MAG:
            begin
                aw_reg <= prod_reg[31:15];
            end
            ST_ACC:
            begin
                sum_reg <= neg_reg ? sum_reg - SUM_W'(term) : sum_reg + SUM_W'(term);
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            if (sum_reg > SUM_MAX)
            begin
                sample_reg  <= 8'sd127;
                clipped_reg <= 1'b1;
            end
            else if (sum_reg < SUM_MIN)
            begin
                sample_reg  <= -8'sd128;
                clipped_reg <= 1'b1;
            end
            else
            begin
                sample_reg  <= sum_reg[7:0];
                clipped_reg <= 1'b0;
            end
        end
    end

    assign mix.valid   = out_valid_reg;
    assign mix.sample  = sample_reg;
    assign mix.clipped = clipped_reg;

endmodule

// ===== rtl/pom_checker.sv =====
// port-level assertions for the oscillator mixer, bound to the top level
module pom_checker
    import pom_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              tick_valid,
    input logic              tick_ready,
    input logic              mix_valid,
    input logic              mix_ready,
    input logic signed [7:0] mix_sample,
    input logic              mix_clipped
);

    // one item at a time: no new item straight after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> !tick_ready)
        else $error("item accepted on back-to-back cycles");

    // a clipped sample sits at one of the two rails
    assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && mix_clipped) |-> (mix_sample == 8'sd127 || mix_sample == -8'sd128))
        else $error("clipped sample not at a rail");

    // stalled sample holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && !mix_ready) |=> (mix_valid && $stable(mix_sample) && $stable(mix_clipped)))
        else $error("stalled sample changed");

endmodule

bind polyphonic_oscillator_mixer_unit pom_checker u_pom_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .mix_valid   (mix.valid),
    .mix_ready   (mix.ready),
    .mix_sample  (mix.sample),
    .mix_clipped (mix.clipped)
);

// ===== tb/sv/tb_polyphonic_oscillator_mixer_unit.sv =====
// self-checking testbench of the oscillator mixer: directed and random key ticks against a predictor
`timescale 1ns / 100ps

module tb_polyphonic_oscillator_mixer_unit;
    import pom_pkg::*;

    localparam int VOICE_COUNT   = 16;
    localparam int SINE_BITS     = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int LIMIT_CYCLES  = 3000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam logic [30:0]          DEFAULT_BASE = 31'd19685267;

    typedef struct packed {
        logic signed [7:0] sample;
        logic              clipped;
    } mix_result_t;

    logic clk;
    logic rst_n;

    pom_cfg_if    cfg_ch ();
    pom_tick_if   tick_ch ();
    pom_sample_if mix_ch ();

    polyphonic_oscillator_mixer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .tick  (tick_ch),
        .mix   (mix_ch)
    );

    logic [16:0] semitone_ratio [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    logic [31:0] synth_phase [VOICE_COUNT];
    wave_t       wave_sel;
    logic [7:0]  gain;
    logic [30:0] base_step;

    mix_result_t expected_mix [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          steady         = 1'b0;
    bit          hold_request   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] voice_increment(input int j);
        logic [63:0] ratio;
        logic [63:0] prod;
        ratio = 64'(semitone_ratio[j % 12]) << (j / 12);
        prod  = 64'(base_step) * ratio;
        return prod[47:16];
    endfunction

    function automatic int fold_quarter(input logic [31:0] u, input bit curve);
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] inner;
        logic [31:0] mid;
        logic [31:0] mag;
        x = {17'd0, u[29:15]};
        if (u[30])
            x = 32'd32768 - x;
        if (curve)
        begin
            x2    = (x * x) >> 15;
            inner = 32'd21024 - ((x2 * 32'd2320) >> 15);
            mid   = 32'd51472 - ((x2 * inner) >> 15);
            mag   = (x * mid) >> 15;
        end
        else
            mag = x;
        return u[31] ? -int'(mag) : int'(mag);
    endfunction

    function automatic int wave_value(input logic [31:0] p);
        case (wave_sel)
            WAVE_SINE:     return fold_quarter(p & ~((32'd1 << (32 - SINE_BITS)) - 32'd1), 1'b1);
            WAVE_TRIANGLE: return fold_quarter(p, 1'b0);
            WAVE_SQUARE:   return p[31] ? -32768 : 32768;
            default:       return int'({16'd0, p[31:16]}) - 32768;
        endcase
    endfunction

    function automatic mix_result_t predict_mix(input logic [15:0] keys);
        mix_result_t r;
        int          total;
        int          w;
        int          mag;
        logic [31:0] aw;
        total = 0;
        for (int j = 0; j < VOICE_COUNT; j++)
        begin
            if (keys[j])
            begin
                w     = wave_value(synth_phase[j]);
                aw    = (w < 0) ? 32'(-w) : 32'(w);
                mag   = int'((aw * {24'd0, gain} * 32'd127) >> 23);
                total = total + ((w < 0) ? -mag : mag);
            end
            synth_phase[j] = synth_phase[j] + voice_increment(j);
        end
        r.clipped = 1'b0;
        if (total > 127)
        begin
            total     = 127;
            r.clipped = 1'b1;
        end
        else if (total < -128)
        begin
            total     = -128;
            r.clipped = 1'b1;
        end
        r.sample = total[7:0];
        return r;
    endfunction

    task automatic play_tick(input logic [15:0] keys);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.key_mask <= keys;
        @(posedge clk);
        while (tick_ch.ready !== 1'b1) @(posedge clk);
        expected_mix.push_back(predict_mix(keys));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        case (idx)
            CFG_WAVEFORM: wave_sel  = wave_t'(value[1:0]);
            CFG_VOLUME:   gain      = value[7:0];
            CFG_BASE_INC: base_step = value;
            default:      ;
        endcase
    endtask

    task automatic set_config(input wave_t wave, input logic [7:0] vol, input logic [30:0] base);
        write_reg(CFG_WAVEFORM, 31'(wave));
        write_reg(CFG_VOLUME, 31'(vol));
        write_reg(CFG_BASE_INC, base);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge clk);
    endtask

    task automatic run_setting(input wave_t wave, input logic [7:0] vol,
                               input logic [30:0] base, input int count);
        logic [15:0] keys;
        wait_drained();
        set_config(wave, vol, base);
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= count / 2) && (i < count / 2 + 20);
            case ($urandom_range(0, 9))
                0:       keys = 16'h0000;
                1:       keys = 16'hFFFF;
                2:       keys = 16'h0001 << $urandom_range(0, 15);
                3:       keys = ~(16'h0001 << $urandom_range(0, 15));
                default: keys = 16'($urandom);
            endcase
            play_tick(keys);
        end
        steady = 1'b0;
    endtask

    task automatic test_reset_defaults();
        play_tick(16'hFFFF);
        play_tick(16'hFFFF);
    endtask

    task automatic test_saturation();
        // phases still near zero, so every sawtooth term is close to full negative
        wait_drained();
        set_config(WAVE_SAWTOOTH, 8'd255, DEFAULT_BASE);
        play_tick(16'hFFFF);
        wait_drained();
        set_config(WAVE_SQUARE, 8'd255, 31'd0);
        play_tick(16'hFFFF);
        play_tick(16'h0000);
        play_tick(16'h0001);
        play_tick(16'h8000);
        wait_drained();
        set_config(WAVE_SQUARE, 8'd255, 31'h7FFFFFFF);
        play_tick(16'hFFFF);
        play_tick(16'hFFFF);
    endtask

    task automatic test_register_fields();
        // upper data bits beyond each register's width must be dropped
        wait_drained();
        write_reg(CFG_WAVEFORM, 31'h7FFFFFFD);
        write_reg(CFG_VOLUME, 31'h7FFFFF00);
        write_reg(CFG_UNUSED, 31'($urandom));
        cfg_ch.valid <= 1'b0;
        play_tick(16'hFFFF);
        play_tick(16'h1234);
        wait_drained();
        write_reg(CFG_VOLUME, 31'h7FFFFE01);
        write_reg(CFG_UNUSED, 31'h7FFFFFFF);
        cfg_ch.valid <= 1'b0;
        play_tick(16'hFFFF);
        play_tick(16'hAAAA);
    endtask

    task automatic test_waveforms();
        for (int w = 0; w < 4; w++)
        begin
            wait_drained();
            set_config(wave_t'(w), 8'd160, DEFAULT_BASE);
            play_tick(16'h5555);
            play_tick(16'hFFFF);
        end
    endtask

    task automatic test_random_settings();
        run_setting(WAVE_SINE, 8'd255, 31'($urandom), 110);
        run_setting(WAVE_TRIANGLE, 8'd128, 31'h7FFFFFFF, 105);
        run_setting(WAVE_SQUARE, 8'($urandom), 31'($urandom_range(0, 16777215)), 105);
        run_setting(WAVE_SAWTOOTH, 8'd1, 31'($urandom), 100);
        run_setting(wave_t'($urandom_range(0, 3)), 8'($urandom), 31'($urandom), 105);
        run_setting(WAVE_SINE, 8'd200, DEFAULT_BASE, 105);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            play_tick(16'($urandom));
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        tick_ch.valid    <= 1'b0;
        tick_ch.key_mask <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        for (int j = 0; j < VOICE_COUNT; j++)
            synth_phase[j] = 32'd0;
        wave_sel  = WAVE_SINE;
        gain      = 8'd51;
        base_step = DEFAULT_BASE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation();
        test_register_fields();
        test_waveforms();
        test_random_settings();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_mix.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        mix_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                mix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mix_ch.ready <= 1'b1;
            @(posedge clk);
            while (mix_ch.valid !== 1'b1) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_mix
        mix_result_t want;
        if (rst_n === 1'b1 && mix_ch.valid === 1'b1 && mix_ch.ready === 1'b1)
        begin
            if (expected_mix.size() == 0)
            begin
                $display("%0t unexpected item: sample %0d clipped %0b",
                         $time, mix_ch.sample, mix_ch.clipped);
                mismatch_count++;
            end
            else
            begin
                want = expected_mix.pop_front();
                if (mix_ch.sample !== want.sample)
                begin
                    $display("%0t sample mismatch: expected %0d, actual %0d",
                             $time, want.sample, mix_ch.sample);
                    mismatch_count++;
                end
                if (mix_ch.clipped !== want.clipped)
                begin
                    $display("%0t clipped mismatch: expected %0b, actual %0b",
                             $time, want.clipped, mix_ch.clipped);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
            || (mix_ch.valid === 1'b1 && mix_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
